>>> sv/cpfa_pkg.sv
// shared types and constants for the contiguous page frame allocator
`timescale 1ns / 1ps

package cpfa_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int IDX_W     = $clog2(MAX_PAGES);
    localparam int CNT_W     = 11;
    localparam int FRAME_W   = 20;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [CNT_W-1:0] RESET_PAGES = CNT_W'(1024);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_MANAGED_PAGES = 1'b0;
    localparam logic REG_BASE_FRAME    = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]   managed_pages;
        logic [FRAME_W-1:0] base_frame;
        logic               clear_start;
    } cfg_t;

    typedef struct packed {
        logic used;
        logic last;
    } page_ent_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        page_ent_t        wr_data;
    } ram_req_t;

endpackage

>>> sv/cpfa_page_ram.sv
// page state memory: used bit and end-of-run mark per page, registered read
`timescale 1ns / 1ps

module cpfa_page_ram (
    input  logic                clk,
    input  cpfa_pkg::ram_req_t  req,
    output cpfa_pkg::page_ent_t rd_data
);
    import cpfa_pkg::*;

    page_ent_t mem [MAX_PAGES];
    page_ent_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/cpfa_cfg.sv
// apb configuration registers for the page frame allocator
`timescale 1ns / 1ps

module cpfa_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpfa_pkg::ADDR_W-1:0]   paddr,
    input  logic [cpfa_pkg::DATA_W-1:0]   pwdata,
    output logic [cpfa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output cpfa_pkg::cfg_t                cfg
);
    import cpfa_pkg::*;

    logic [CNT_W-1:0]   managed_pages_reg;
    logic [FRAME_W-1:0] base_frame_reg;
    logic               clear_reg;
    logic               wr_fire;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_fire = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            managed_pages_reg <= RESET_PAGES;
            base_frame_reg    <= '0;
            clear_reg         <= 1'b0;
        end
        else
        begin
            clear_reg <= 1'b0;
            if (wr_fire)
            begin
                if (reg_sel == REG_MANAGED_PAGES)
                begin
                    managed_pages_reg <= pwdata[CNT_W-1:0];
                    clear_reg         <= 1'b1;
                end
                else
                begin
                    base_frame_reg <= pwdata[FRAME_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_MANAGED_PAGES)
        begin
            prdata = DATA_W'(managed_pages_reg);
        end
        else
        begin
            prdata = DATA_W'(base_frame_reg);
        end
    end

    assign cfg.managed_pages = managed_pages_reg;
    assign cfg.base_frame    = base_frame_reg;
    assign cfg.clear_start   = clear_reg;

endmodule

>>> sv/cpfa_engine.sv
// allocate and free sequencer: scans, marks and walks the page memory
`timescale 1ns / 1ps

module cpfa_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cpfa_pkg::cfg_t                 cfg,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic                           cmd,
    input  logic [cpfa_pkg::CNT_W-1:0]     page_count,
    input  logic [cpfa_pkg::FRAME_W-1:0]   free_frame,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic                           ok,
    output logic [cpfa_pkg::FRAME_W-1:0]   first_frame,
    output logic [cpfa_pkg::CNT_W-1:0]     pages_free,
    output cpfa_pkg::ram_req_t             ram_req,
    input  cpfa_pkg::page_ent_t            ram_rd
);
    import cpfa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   next_fit_reg, next_fit_next;
    logic [CNT_W-1:0]   free_total_reg, free_total_next;
    logic               res_ok_reg, res_ok_next;
    logic [FRAME_W-1:0] res_first_reg, res_first_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               ok_reg, ok_next;
    logic [FRAME_W-1:0] first_frame_reg, first_frame_next;
    logic [CNT_W-1:0]   pages_free_reg, pages_free_next;

    logic [CNT_W-1:0]   lim;
    logic               addr_top;
    logic               pos_top;
    logic               end_top;
    logic               accept;
    logic [FRAME_W-1:0] free_idx;
    logic               free_in_range;
    logic [IDX_W-1:0]   run_start;

    assign lim = (32'(cfg.managed_pages) > MAX_PAGES) ? CNT_W'(MAX_PAGES)
                                                       : cfg.managed_pages;
    assign addr_top = (32'(addr_reg) + 32'd1 >= 32'(lim));
    assign pos_top  = (32'(pos_reg) + 32'd1 >= 32'(lim));
    assign end_top  = (32'(end_reg) + 32'd1 >= 32'(lim));

    assign req_ready = (state_reg == S_IDLE) && !cfg.clear_start;
    assign accept    = req_valid && req_ready;

    assign free_idx      = free_frame - cfg.base_frame;
    assign free_in_range = (free_frame >= cfg.base_frame) && (32'(free_idx) < 32'(lim));
    assign run_start     = pos_reg + IDX_W'(1) - IDX_W'(count_reg);

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        pos_next         = pos_reg;
        pend_next        = pend_reg;
        run_next         = run_reg;
        seen_next        = seen_reg;
        end_next         = end_reg;
        count_next       = count_reg;
        next_fit_next    = next_fit_reg;
        free_total_next  = free_total_reg;
        res_ok_next      = res_ok_reg;
        res_first_next   = res_first_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        ok_next          = ok_reg;
        first_frame_next = first_frame_reg;
        pages_free_next  = pages_free_reg;

        ram_req.rd_addr  = addr_reg;
        ram_req.wr_en    = 1'b0;
        ram_req.wr_addr  = addr_reg;
        ram_req.wr_data  = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_req.wr_en = 1'b1;
                addr_next     = addr_reg + IDX_W'(1);
                if (addr_reg == IDX_W'(MAX_PAGES - 1))
                begin
                    free_total_next = lim;
                    next_fit_next   = '0;
                    state_next      = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next = 1'b0;
                    run_next  = '0;
                    seen_next = '0;
                    if (cmd == CMD_ALLOC)
                    begin
                        count_next = page_count;
                        addr_next  = next_fit_reg;
                        if (page_count == '0 || page_count > lim
                            || 32'(next_fit_reg) >= 32'(lim))
                        begin
                            res_ok_next    = 1'b0;
                            res_first_next = '0;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        addr_next = free_idx[IDX_W-1:0];
                        if (free_in_range)
                        begin
                            state_next = S_FREE;
                        end
                        else
                        begin
                            res_ok_next    = 1'b0;
                            res_first_next = '0;
                            state_next     = S_DONE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                addr_next = addr_top ? '0 : addr_reg + IDX_W'(1);
                pos_next  = addr_reg;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (!ram_rd.used && (run_reg + CNT_W'(1) == count_reg))
                    begin
                        end_next       = pos_reg;
                        addr_next      = run_start;
                        res_first_next = cfg.base_frame + FRAME_W'(run_start);
                        state_next     = S_MARK;
                    end
                    else
                    begin
                        if (ram_rd.used || pos_top)
                        begin
                            run_next = '0;
                        end
                        else
                        begin
                            run_next = run_reg + CNT_W'(1);
                        end
                        seen_next = seen_reg + CNT_W'(1);
                        if (seen_reg + CNT_W'(1) == lim)
                        begin
                            res_ok_next    = 1'b0;
                            res_first_next = '0;
                            state_next     = S_DONE;
                        end
                    end
                end
            end
            S_MARK:
            begin
                ram_req.wr_en        = 1'b1;
                ram_req.wr_data.used = 1'b1;
                ram_req.wr_data.last = (addr_reg == end_reg);
                addr_next            = addr_reg + IDX_W'(1);
                if (addr_reg == end_reg)
                begin
                    free_total_next = (free_total_reg >= count_reg)
                                      ? free_total_reg - count_reg : '0;
                    next_fit_next   = end_top ? '0 : end_reg + IDX_W'(1);
                    res_ok_next     = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_FREE:
            begin
                addr_next       = addr_reg + IDX_W'(1);
                pos_next        = addr_reg;
                pend_next       = 1'b1;
                ram_req.wr_addr = pos_reg;
                if (pend_reg)
                begin
                    ram_req.wr_en = 1'b1;
                    if (ram_rd.used && free_total_reg < lim)
                    begin
                        free_total_next = free_total_reg + CNT_W'(1);
                    end
                    if (ram_rd.last || pos_top)
                    begin
                        res_ok_next    = 1'b1;
                        res_first_next = '0;
                        state_next     = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next   = 1'b1;
                    ok_next          = res_ok_reg;
                    first_frame_next = res_first_reg;
                    pages_free_next  = free_total_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // restart the sweep whenever the page count is rewritten
        if (cfg.clear_start)
        begin
            addr_next  = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            next_fit_reg   <= '0;
            free_total_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            pend_reg       <= pend_next;
            next_fit_reg   <= next_fit_next;
            free_total_reg <= free_total_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        run_reg         <= run_next;
        seen_reg        <= seen_next;
        end_reg         <= end_next;
        count_reg       <= count_next;
        res_ok_reg      <= res_ok_next;
        res_first_reg   <= res_first_next;
        ok_reg          <= ok_next;
        first_frame_reg <= first_frame_next;
        pages_free_reg  <= pages_free_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign ok          = ok_reg;
    assign first_frame = first_frame_reg;
    assign pages_free  = pages_free_reg;

endmodule

>>> sv/contiguous_page_frame_allocator.sv
// top level of the next-fit contiguous page frame allocator
//
//  channel   signals                                   direction
//  req       req_valid req_ready cmd page_count         in
//            free_frame
//  rsp       rsp_valid rsp_ready ok first_frame         out
//            pages_free
//  apb       psel penable pwrite paddr pwdata           in
//            prdata pready
//
// alloc scans the pages from the next-fit point at one page read a cycle, then marks
// the run, then loads the result word.
// free walks the pages up to the end mark and clears them.
// after reset and after each write of managed_pages a sweep clears all 1024 entries of
// the page memory; no word is taken meanwhile, apb writes still are.
// a held result word does not stop the next request, only the next result load.
`timescale 1ns / 1ps

module contiguous_page_frame_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpfa_pkg::ADDR_W-1:0]   paddr,
    input  logic [cpfa_pkg::DATA_W-1:0]   pwdata,
    output logic [cpfa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          cmd,
    input  logic [cpfa_pkg::CNT_W-1:0]    page_count,
    input  logic [cpfa_pkg::FRAME_W-1:0]  free_frame,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          ok,
    output logic [cpfa_pkg::FRAME_W-1:0]  first_frame,
    output logic [cpfa_pkg::CNT_W-1:0]    pages_free
);
    import cpfa_pkg::*;

    cfg_t      cfg;
    ram_req_t  ram_req;
    page_ent_t ram_rd;

    cpfa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpfa_page_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    cpfa_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .page_count  (page_count),
        .free_frame  (free_frame),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .ok          (ok),
        .first_frame (first_frame),
        .pages_free  (pages_free),
        .ram_req     (ram_req),
        .ram_rd      (ram_rd)
    );

endmodule

>>> tb/sv/contiguous_page_frame_allocator_tb.sv
// self-checking testbench for the contiguous page frame allocator, with a built-in predictor
`timescale 1ns / 1ps

module contiguous_page_frame_allocator_tb;
    import cpfa_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic               cmd;
        logic [CNT_W-1:0]   page_count;
        logic [FRAME_W-1:0] free_frame;
    } page_req_t;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] first_frame;
        logic [CNT_W-1:0]   pages_free;
    } page_rsp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic               cmd = CMD_ALLOC;
    logic [CNT_W-1:0]   page_count = '0;
    logic [FRAME_W-1:0] free_frame = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic               ok;
    logic [FRAME_W-1:0] first_frame;
    logic [CNT_W-1:0]   pages_free;

    idle_mode_t         idle_mode = IDLE_NONE;
    page_req_t          pending_words[$];
    page_rsp_t          expected_words[$];
    logic [FRAME_W-1:0] live_runs[$];
    page_req_t          next_word;
    page_rsp_t          want;
    int                 mismatches = 0;

    // predictor state
    bit                 page_busy[MAX_PAGES];
    bit                 run_last[MAX_PAGES];
    int                 fit_ptr = 0;
    int                 free_pages = MAX_PAGES;
    logic [CNT_W-1:0]   cfg_pages = RESET_PAGES;
    logic [FRAME_W-1:0] cfg_base = '0;

    contiguous_page_frame_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .page_count  (page_count),
        .free_frame  (free_frame),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .ok          (ok),
        .first_frame (first_frame),
        .pages_free  (pages_free)
    );

    always #6 clk = ~clk;

    function automatic int active_pages();
        return (cfg_pages > MAX_PAGES) ? MAX_PAGES : int'(cfg_pages);
    endfunction

    function automatic bit hold_sender();
        return (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) &&
               $urandom_range(99) < ((idle_mode == IDLE_SENDER) ? 72 : 32);
    endfunction

    function automatic bit hold_receiver();
        return (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH) &&
               $urandom_range(99) < ((idle_mode == IDLE_RECEIVER) ? 72 : 32);
    endfunction

    // next-fit search or release walk, updating the page map
    function automatic page_rsp_t predict_word(page_req_t w);
        page_rsp_t r;
        int        lim;
        int        pos;
        int        run;
        int        idx;
        int        i;
        bit        hit;
        bit        last;
        lim = active_pages();
        r = '0;
        if (w.cmd == CMD_ALLOC)
        begin
            pos = fit_ptr;
            run = 0;
            hit = 1'b0;
            if (w.page_count != 0 && w.page_count <= lim && pos < lim)
            begin
                for (i = 0; i < lim && !hit; i++)
                begin
                    if (page_busy[pos])
                        run = 0;
                    else
                        run++;
                    if (run == w.page_count)
                    begin
                        hit = 1'b1;
                        for (idx = pos + 1 - run; idx <= pos; idx++)
                        begin
                            page_busy[idx] = 1'b1;
                            run_last[idx] = 1'b0;
                        end
                        run_last[pos] = 1'b1;
                        free_pages = (free_pages >= run) ? free_pages - run : 0;
                        fit_ptr = (pos + 1 >= lim) ? 0 : pos + 1;
                        r.ok = 1'b1;
                        r.first_frame = cfg_base + FRAME_W'(pos + 1 - run);
                        live_runs.push_back(r.first_frame);
                    end
                    else
                    begin
                        pos++;
                        // runs never wrap past the top page
                        if (pos >= lim)
                        begin
                            pos = 0;
                            run = 0;
                        end
                    end
                end
            end
        end
        else
        begin
            idx = int'(w.free_frame) - int'(cfg_base);
            if (idx >= 0 && idx < lim)
            begin
                r.ok = 1'b1;
                last = 1'b0;
                while (!last && idx < lim)
                begin
                    last = run_last[idx];
                    if (page_busy[idx] && free_pages < lim)
                        free_pages++;
                    page_busy[idx] = 1'b0;
                    run_last[idx] = 1'b0;
                    idx++;
                end
            end
        end
        r.pages_free = CNT_W'(free_pages);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_words.size() != 0 && !hold_sender())
            begin
                next_word = pending_words.pop_front();
                req_valid <= 1'b1;
                cmd <= next_word.cmd;
                page_count <= next_word.page_count;
                free_frame <= next_word.free_frame;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        rsp_ready <= !hold_receiver();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (ok !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, ok);
                        mismatches++;
                    end
                    if (first_frame !== want.first_frame)
                    begin
                        $error("first_frame: expected %0h, got %0h",
                               want.first_frame, first_frame);
                        mismatches++;
                    end
                    if (pages_free !== want.pages_free)
                    begin
                        $error("pages_free: expected %0d, got %0d",
                               want.pages_free, pages_free);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_words.push_back(predict_word('{cmd, page_count, free_frame}));
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
        wait_idle();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MANAGED_PAGES)
        begin
            cfg_pages = value[CNT_W-1:0];
            page_busy = '{default: 1'b0};
            run_last = '{default: 1'b0};
            fit_ptr = 0;
            free_pages = active_pages();
        end
        else
        begin
            cfg_base = value[FRAME_W-1:0];
        end
        live_runs.delete();
    endtask

    task automatic queue_word(logic c, int count, int frame);
        page_req_t w;
        @(negedge clk);
        while (pending_words.size() >= 2)
            @(negedge clk);
        w.cmd = c;
        w.page_count = CNT_W'(count);
        w.free_frame = FRAME_W'(frame);
        pending_words.push_back(w);
    endtask

    // mostly allocs and frees of live runs, some stray frees and odd counts
    task automatic random_word();
        page_req_t w;
        int        lim;
        int        r;
        int        k;
        @(negedge clk);
        while (pending_words.size() >= 2)
            @(negedge clk);
        lim = active_pages();
        r = $urandom_range(99);
        w.page_count = CNT_W'($urandom);
        w.free_frame = FRAME_W'($urandom);
        if (r < 45 || (r < 85 && live_runs.size() == 0))
        begin
            w.cmd = CMD_ALLOC;
            k = $urandom_range(99);
            if (k < 70)
                w.page_count = CNT_W'($urandom_range(1, (lim >= 8) ? lim / 4 : 2));
            else if (k < 92)
                w.page_count = CNT_W'($urandom_range(1, lim));
        end
        else if (r < 85)
        begin
            w.cmd = CMD_FREE;
            k = $urandom_range(live_runs.size() - 1);
            w.free_frame = live_runs[k];
            live_runs.delete(k);
            // sometimes start inside the run
            if ($urandom_range(4) == 0)
                w.free_frame = w.free_frame + FRAME_W'($urandom_range(3));
        end
        else
        begin
            w.cmd = CMD_FREE;
            if ($urandom_range(1) == 0)
                w.free_frame = cfg_base + FRAME_W'($urandom_range(lim + 3));
        end
        pending_words.push_back(w);
    endtask

    initial
    begin
        int ph;
        int n;
        int pages;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 1024 pages from frame 0
        queue_word(CMD_ALLOC, 0, 0);
        queue_word(CMD_ALLOC, 2047, 0);
        queue_word(CMD_ALLOC, 1025, 0);
        queue_word(CMD_ALLOC, 1, 0);
        queue_word(CMD_ALLOC, 1022, 0);
        queue_word(CMD_ALLOC, 1, 0);
        queue_word(CMD_ALLOC, 1, 0);
        queue_word(CMD_FREE, 0, 20'hFFFFF);
        queue_word(CMD_FREE, 0, 1024);
        queue_word(CMD_FREE, 0, 1);
        queue_word(CMD_FREE, 0, 1);
        queue_word(CMD_ALLOC, 1024, 0);
        queue_word(CMD_FREE, 0, 0);
        queue_word(CMD_ALLOC, 1024, 0);
        queue_word(CMD_FREE, 0, 0);
        queue_word(CMD_ALLOC, 5, 0);
        queue_word(CMD_ALLOC, 3, 0);
        queue_word(CMD_FREE, 0, 2);
        queue_word(CMD_ALLOC, 2, 0);

        // single page at the top of the frame space
        write_reg(REG_BASE_FRAME, 32'h000F_FFFF);
        write_reg(REG_MANAGED_PAGES, 1);
        queue_word(CMD_ALLOC, 1, 0);
        queue_word(CMD_ALLOC, 1, 0);
        queue_word(CMD_FREE, 0, 20'hFFFFE);
        queue_word(CMD_FREE, 0, 20'hFFFFF);

        // frame numbers wrap past 2^20
        write_reg(REG_MANAGED_PAGES, 2);
        queue_word(CMD_ALLOC, 1, 0);
        queue_word(CMD_ALLOC, 1, 0);
        queue_word(CMD_FREE, 0, 0);

        for (ph = 0; ph < 12; ph++)
        begin
            if (ph == 0)
                pages = 1024;
            else if (ph == 6)
                pages = 1023;
            else if (ph == 3)
                pages = 1;
            else if (ph == 9)
                pages = 2;
            else
                pages = $urandom_range(3, 96);
            if (ph % 3 == 0)
                write_reg(REG_BASE_FRAME, $urandom_range(20'hFFFFF - 200, 20'hFFFFF));
            else
                write_reg(REG_BASE_FRAME, $urandom_range(20'hFFFFF));
            write_reg(REG_MANAGED_PAGES, pages);
            idle_mode = idle_mode_t'(ph % 4);
            for (n = 0; n < 36; n++)
                random_word();
        end

        wait_idle();
        if (mismatches == 0)
            $display("contiguous_page_frame_allocator_tb: done, clean");
        else
            $display("contiguous_page_frame_allocator_tb: done, errors");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("contiguous_page_frame_allocator_tb: done, errors");
        $finish;
    end

endmodule
